@@ design/uffgd_pkg.sv @@
// uffgd_pkg: widths, codes and shared types of the first-gap-day union-find block
// no dependencies; every other design file except uffgd_ram refers to it by scoped names

package uffgd_pkg;

  // largest node index the parent table holds
  localparam int NODE_COUNT_MAX = 1024;
  localparam int ADDR_W         = $clog2(NODE_COUNT_MAX);
  localparam int NODE_W         = 11;
  localparam int DAY_W          = 20;

  // command codes of the input channel
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EDGE  = 1'b1;

  // request from the controller to the parent table
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // finished answer handed to the output stage
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] day;
  } result_t;

endpackage

@@ design/uffgd_if.sv @@
// uffgd_if: valid/ready channel interfaces for edge items and answers
// depends on uffgd_pkg for field widths

interface uffgd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [uffgd_pkg::NODE_W-1:0] node_a;
  logic [uffgd_pkg::NODE_W-1:0] node_b;
  logic [uffgd_pkg::DAY_W-1:0]  edge_day;
  logic                        last;

  modport source (output valid, command, node_a, node_b, edge_day, last, input ready);
  modport sink   (input valid, command, node_a, node_b, edge_day, last, output ready);
endinterface

interface uffgd_out_if;
  logic                        valid;
  logic                        ready;
  logic [uffgd_pkg::NODE_W-1:0] answer_day;

  modport source (output valid, answer_day, input ready);
  modport sink   (input valid, answer_day, output ready);
endinterface

@@ design/uffgd_ram.sv @@
// uffgd_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies

module uffgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/uffgd_out_reg.sv @@
// uffgd_out_reg: output register that holds one answer until the receiver takes it
// depends on uffgd_pkg and uffgd_out_if

module uffgd_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  uffgd_pkg::result_t res,
  output logic               busy,
  uffgd_out_if.source        results
);

  logic                         valid;
  logic [uffgd_pkg::NODE_W-1:0] day;

  assign busy = valid && !results.ready;

  // load when empty or when the held answer is being transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res.valid && !busy) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && !busy) begin
      day <= res.day;
    end
  end

  assign results.valid      = valid;
  assign results.answer_day = day;

endmodule

@@ design/uffgd_ctrl.sv @@
// uffgd_ctrl: sequencer for table sweeps, root walks, union and answer decision
// depends on uffgd_pkg and uffgd_in_if; drives the parent table RAM

module uffgd_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [uffgd_pkg::NODE_W-1:0] cfg_wdata,
  uffgd_in_if.sink                     edges,
  output uffgd_pkg::mem_req_t          mem_req,
  input  logic [uffgd_pkg::NODE_W-1:0] mem_rdata,
  output uffgd_pkg::result_t           res,
  input  logic                         out_busy
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_INIT  = 6'b000100,
    S_WALKA = 6'b001000,
    S_WALKB = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  localparam logic [uffgd_pkg::NODE_W-1:0] MAX_N =
    uffgd_pkg::NODE_W'(uffgd_pkg::NODE_COUNT_MAX);
  localparam logic [uffgd_pkg::NODE_W-1:0] ONE = uffgd_pkg::NODE_W'(1);

  state_t                       state, state_next;
  logic [uffgd_pkg::NODE_W-1:0] node_count;
  logic [uffgd_pkg::NODE_W-1:0] day_counter, day_counter_next;
  logic                         done, done_next;
  logic [uffgd_pkg::NODE_W-1:0] sweep, sweep_next;
  logic [uffgd_pkg::NODE_W-1:0] cur, cur_next;
  logic [uffgd_pkg::NODE_W-1:0] root_a, root_a_next;
  logic [uffgd_pkg::NODE_W-1:0] node_b, node_b_next;
  logic [uffgd_pkg::DAY_W-1:0]  edge_day, edge_day_next;
  logic                         last, last_next;
  logic [uffgd_pkg::NODE_W-1:0] answer, answer_next;

  logic [uffgd_pkg::NODE_W-1:0] eff_count;
  logic                         accept;
  logic                         ends_valid;
  logic                         at_root;
  logic [uffgd_pkg::NODE_W-1:0] ctr_inc;
  logic [uffgd_pkg::NODE_W-1:0] root_lo, root_hi;

  // effective node count and endpoint range check
  assign eff_count  = (node_count > MAX_N) ? MAX_N : node_count;
  assign ends_valid = (edges.node_a >= ONE) && (edges.node_a <= eff_count) &&
                      (edges.node_b >= ONE) && (edges.node_b <= eff_count);

  assign edges.ready = (state == S_IDLE);
  assign accept      = edges.valid && edges.ready;
  assign at_root     = (mem_rdata == cur);
  assign ctr_inc     = day_counter + ONE;
  assign root_lo     = (root_a < cur) ? root_a : cur;
  assign root_hi     = (root_a < cur) ? cur : root_a;

  assign res.valid = (state == S_EMIT);
  assign res.day   = answer;

  // next state, table requests and answer decision
  always_comb begin
    state_next       = state;
    day_counter_next = day_counter;
    done_next        = done;
    sweep_next       = sweep;
    cur_next         = cur;
    root_a_next      = root_a;
    node_b_next      = node_b;
    edge_day_next    = edge_day;
    last_next        = last;
    answer_next      = answer;
    mem_req.we       = 1'b0;
    mem_req.waddr    = sweep[uffgd_pkg::ADDR_W-1:0];
    mem_req.wdata    = sweep + ONE;
    mem_req.raddr    = '0;

    unique case (state)
      S_CLEAR: begin
        mem_req.we = 1'b1;
        sweep_next = sweep + ONE;
        if (sweep + ONE == MAX_N) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        sweep_next    = '0;
        cur_next      = edges.node_a;
        node_b_next   = edges.node_b;
        edge_day_next = edges.edge_day;
        last_next     = edges.last;
        mem_req.raddr = uffgd_pkg::ADDR_W'(edges.node_a - ONE);
        if (accept) begin
          if (edges.command == uffgd_pkg::CMD_START) begin
            day_counter_next = '0;
            done_next        = 1'b0;
            if (eff_count != '0) begin
              state_next = S_INIT;
            end
          end else if (!done) begin
            if (ends_valid) begin
              state_next = S_WALKA;
            end else if (edges.last) begin
              answer_next = ctr_inc;
              done_next   = 1'b1;
              state_next  = S_EMIT;
            end
          end
        end
      end

      S_INIT: begin
        mem_req.we = 1'b1;
        sweep_next = sweep + ONE;
        if (sweep + ONE == eff_count) begin
          state_next = S_IDLE;
        end
      end

      S_WALKA: begin
        if (at_root) begin
          root_a_next   = cur;
          cur_next      = node_b;
          mem_req.raddr = uffgd_pkg::ADDR_W'(node_b - ONE);
          state_next    = S_WALKB;
        end else begin
          cur_next      = mem_rdata;
          mem_req.raddr = uffgd_pkg::ADDR_W'(mem_rdata - ONE);
        end
      end

      S_WALKB: begin
        if (at_root) begin
          state_next = S_IDLE;
          if (root_a != cur) begin
            day_counter_next = ctr_inc;
            if (uffgd_pkg::DAY_W'(ctr_inc) < edge_day) begin
              answer_next = ctr_inc;
              done_next   = 1'b1;
              state_next  = S_EMIT;
            end else begin
              // smaller root becomes the parent of the larger
              mem_req.we    = 1'b1;
              mem_req.waddr = uffgd_pkg::ADDR_W'(root_hi - ONE);
              mem_req.wdata = root_lo;
              if (last) begin
                answer_next = ctr_inc + ONE;
                done_next   = 1'b1;
                state_next  = S_EMIT;
              end
            end
          end else if (last) begin
            answer_next = ctr_inc;
            done_next   = 1'b1;
            state_next  = S_EMIT;
          end
        end else begin
          cur_next      = mem_rdata;
          mem_req.raddr = uffgd_pkg::ADDR_W'(mem_rdata - ONE);
        end
      end

      S_EMIT: begin
        if (!out_busy) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      day_counter <= '0;
      done        <= 1'b0;
      sweep       <= '0;
    end else begin
      state       <= state_next;
      day_counter <= day_counter_next;
      done        <= done_next;
      sweep       <= sweep_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= MAX_N;
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  // item and walk payload
  always_ff @(posedge clk) begin
    cur      <= cur_next;
    root_a   <= root_a_next;
    node_b   <= node_b_next;
    edge_day <= edge_day_next;
    last     <= last_next;
    answer   <= answer_next;
  end

endmodule

@@ design/union_find_first_gap_day.sv @@
// union_find_first_gap_day: top level of the first-gap-day union-find block
// depends on uffgd_pkg, uffgd_if, uffgd_ram, uffgd_ctrl and uffgd_out_reg
//
// Usage:
//   edges   - input channel; command start (re)initialises the parent table
//             for nodes 1..node_count (at most 1024), zeroes the day counter
//             and clears done; command edge joins node_a and node_b unless
//             they share a root, an endpoint lies outside that range, done is
//             set or the new counter would fall below the edge's day.
//   results - one answer_day when a join leaves the counter below the edge's
//             day or on the edge marked last; none until the next start.
//   cfg_we / cfg_wdata - write node_count (reset 1024), only while idle.
// Timing:
//   a valid edge walks both parent chains, one table read per cycle, and edges
//   is not ready until the walk ends; an answer is handed over to the output
//   register from an emit state. A start writes one table entry per cycle.
// Reset: rst clears control state, then a clearing pass writes every table
//   entry as its own root; edges is not ready during the pass.
// Stall: one answer waits in the output register; the block keeps taking
//   items and only holds when a second answer is due before the first leaves.

module union_find_first_gap_day (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [uffgd_pkg::NODE_W-1:0] cfg_wdata,
  uffgd_in_if.sink                     edges,
  uffgd_out_if.source                  results
);

  uffgd_pkg::mem_req_t          mem_req;
  logic [uffgd_pkg::NODE_W-1:0] mem_rdata;
  uffgd_pkg::result_t           res;
  logic                         out_busy;

  // sequencer
  uffgd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .edges     (edges),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res       (res),
    .out_busy  (out_busy)
  );

  // parent table
  uffgd_ram #(
    .WIDTH (uffgd_pkg::NODE_W),
    .DEPTH (uffgd_pkg::NODE_COUNT_MAX)
  ) u_parent (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // answer output register
  uffgd_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .res     (res),
    .busy    (out_busy),
    .results (results)
  );

endmodule

@@ tb/uffgd_checker.sv @@
// uffgd_checker: watches the edge and answer channels of union_find_first_gap_day
// keeps its own parent forest, predicts each answer_day and compares transfers
// depends on uffgd_pkg and the channel interfaces in uffgd_if

module uffgd_checker
  import uffgd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [NODE_W-1:0] cfg_wdata,
  uffgd_in_if               edges,
  uffgd_out_if              results,
  output int                fail_count,
  output int                pending,
  output int                handled
);

  // predicted state of the block
  logic [NODE_W-1:0] forest [0:NODE_COUNT_MAX];
  logic [NODE_W-1:0] join_count;
  logic              gap_found;
  logic [NODE_W-1:0] node_limit;

  // answer days still owed by the block, oldest first
  logic [NODE_W-1:0] gap_days_due [$];

  int fails   = 0;
  int reports = 0;
  int taken   = 0;

  // walk parent links up to the root, bounded like the table depth
  function automatic logic [NODE_W-1:0] root_of(input logic [NODE_W-1:0] n);
    int steps = 0;
    while (n >= 1 && n <= NODE_COUNT_MAX && forest[n] != n && steps < NODE_COUNT_MAX) begin
      n = forest[n];
      steps++;
    end
    return n;
  endfunction

  // apply one accepted item and queue the answer it gives, if any
  task automatic predict_gap_day(input logic cmd, input logic [NODE_W-1:0] a,
                                 input logic [NODE_W-1:0] b, input logic [DAY_W-1:0] day,
                                 input logic fin);
    int lim;
    logic [NODE_W-1:0] ra, rb;
    taken++;
    lim = node_limit > NODE_COUNT_MAX ? NODE_COUNT_MAX : int'(node_limit);
    // start: fresh roots for the nodes in use, other entries kept
    if (cmd == CMD_START) begin
      for (int i = 1; i <= lim; i++) forest[i] = NODE_W'(i);
      join_count = '0;
      gap_found  = 1'b0;
      return;
    end
    // edges after an answer are dropped until the next start
    if (gap_found) return;
    // out-of-range endpoints behave like a skipped edge
    if (a >= 1 && a <= lim && b >= 1 && b <= lim) begin
      ra = root_of(a);
      rb = root_of(b);
      if (ra != rb) begin
        join_count = join_count + 1'b1;
        if (join_count < day) begin
          gap_days_due = {gap_days_due, join_count};
          gap_found = 1'b1;
          return;
        end
        if (ra < rb) forest[rb] = ra;
        else forest[ra] = rb;
      end
    end
    if (fin) begin
      gap_days_due = {gap_days_due, NODE_W'(join_count + 1'b1)};
      gap_found = 1'b1;
    end
  endtask

  task automatic note_failure(input string msg);
    fails++;
    if (reports < 10) $display("%s", msg);
    reports++;
  endtask

  always @(posedge clk) begin
    logic [NODE_W-1:0] want;
    if (rst) begin
      for (int i = 0; i <= NODE_COUNT_MAX; i++) forest[i] = NODE_W'(i);
      join_count = '0;
      gap_found  = 1'b0;
      node_limit = NODE_W'(NODE_COUNT_MAX);
      gap_days_due.delete();
    end else begin
      if (cfg_we) node_limit = cfg_wdata;
      // answer transfer against the oldest prediction
      if (results.valid && results.ready) begin
        if (gap_days_due.size() == 0) begin
          note_failure($sformatf("answer_day %0d transferred with nothing expected",
                                 results.answer_day));
        end else begin
          want = gap_days_due.pop_front();
          if (results.answer_day !== want)
            note_failure($sformatf("answer_day mismatch: expected %0d, got %0d",
                                   want, results.answer_day));
        end
      end
      // item transfer into the predictor
      if (edges.valid && edges.ready)
        predict_gap_day(edges.command, edges.node_a, edges.node_b, edges.edge_day,
                        edges.last);
    end
    fail_count <= fails;
    pending    <= gap_days_due.size();
    handled    <= taken;
  end

endmodule

@@ tb/tb.sv @@
// tb: stimulus and verdict for union_find_first_gap_day
// drives edge graphs under several node counts with random gaps and stalls;
// depends on uffgd_pkg, uffgd_if, the block itself and uffgd_checker

module tb;
  import uffgd_pkg::*;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [NODE_W-1:0] cfg_wdata;

  int fail_count, pending, handled;
  int n_eff, day, sent;
  bit calm, hold_req;

  // node counts per phase: extremes first, the short-graph squeeze at index 5
  int schedule [15] = '{0, 1, 2047, 2, 1024, 3, 5, 1500, 12, 40, 1, 7, 64, 20, 1024};

  uffgd_in_if  edges ();
  uffgd_out_if results ();

  union_find_first_gap_day uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .edges     (edges),
    .results   (results)
  );

  uffgd_checker gap_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .edges      (edges),
    .results    (results),
    .fail_count (fail_count),
    .pending    (pending),
    .handled    (handled)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hang guard
  initial begin
    #120_000_000;
    $display("Some tests failed");
    $finish;
  end

  // answer side: random stalls, one long hold-off on request
  initial begin
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        results.ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else begin
        results.ready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  // one item transfer, with random idle cycles ahead of it
  task automatic send(input int cmd, input int a, input int b, input int d, input int fin);
    if (!calm) begin
      while ($urandom_range(99) < 36) begin
        edges.valid <= 1'b0;
        @(posedge clk);
      end
    end
    edges.valid    <= 1'b1;
    edges.command  <= cmd[0];
    edges.node_a   <= NODE_W'(a);
    edges.node_b   <= NODE_W'(b);
    edges.edge_day <= DAY_W'(d);
    edges.last     <= fin[0];
    do @(posedge clk); while (!edges.ready);
    sent++;
  endtask

  // node count write once the block has drained and finished any walk or start
  task automatic set_node_count(input int v);
    edges.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= NODE_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_eff = v > NODE_COUNT_MAX ? NODE_COUNT_MAX : v;
  endtask

  // endpoint: mostly in range, sometimes zero, the ends of the range or any 11-bit value
  function automatic int pick_node();
    int r = $urandom_range(99);
    if (n_eff == 0 || r < 4) return $urandom_range(2047);
    if (r < 6) return 0;
    if (r < 8) return n_eff;
    if (r < 10) return 1;
    return $urandom_range(1, n_eff);
  endfunction

  // nondecreasing day: mostly flat or +1, with rare jumps
  task automatic advance_day();
    int r;
    r = $urandom_range(99);
    if (r >= 97) day = $urandom_range(day, 20'hFFFFF);
    else if (r >= 90) day += $urandom_range(2, 30);
    else if (r >= 55) day++;
    if (day > 20'hFFFFF) day = 20'hFFFFF;
  endtask

  // one graph: start, optional descending chain, random edges, last on the final one; or noise items
  task automatic run_graph();
    int kind, m, k, len, cap;
    kind = $urandom_range(99);
    day  = $urandom_range(1);
    // noise items with any field values
    if (kind >= 92) begin
      repeat ($urandom_range(1, 4))
        send($urandom_range(1), $urandom_range(2047), $urandom_range(2047),
             $urandom_range(20'hFFFFF), $urandom_range(1));
      return;
    end
    // rarely carry on from the previous graph without a start
    if (kind >= 6)
      send(CMD_START, $urandom_range(2047), $urandom_range(2047),
           $urandom_range(20'hFFFFF), $urandom_range(1));
    // descending chain builds long parent walks
    if (kind >= 70 && n_eff >= 2) begin
      cap = n_eff >= 512 ? 200 : 60;
      len = $urandom_range(1, n_eff - 1 < cap ? n_eff - 1 : cap);
      for (k = n_eff - 1; k >= n_eff - len; k--) send(CMD_EDGE, k + 1, k, 0, 0);
    end
    m = $urandom_range(1, 24);
    for (k = 0; k < m; k++) begin
      advance_day();
      // some graphs are abandoned without a last edge
      send(CMD_EDGE, pick_node(), pick_node(), day, int'(k == m - 1 && kind % 13 != 0));
    end
  endtask

  initial begin
    int p, v, phase_start;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    edges.valid    <= 1'b0;
    edges.command  <= CMD_START;
    edges.node_a   <= '0;
    edges.node_b   <= '0;
    edges.edge_day <= '0;
    edges.last     <= 1'b0;
    calm     = 1'b0;
    hold_req = 1'b0;
    sent     = 0;
    n_eff    = NODE_COUNT_MAX;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset node count
    send(CMD_EDGE, 1, 2, 0, 0);                     // before any start, day zero joins
    send(CMD_EDGE, 1024, 1023, 1, 0);               // top node
    send(CMD_EDGE, 0, 5, 1, 0);                     // endpoint zero
    send(CMD_EDGE, 2047, 3, 2, 0);                  // endpoint past the count
    send(CMD_EDGE, 2, 1, 2, 0);                     // shared root
    send(CMD_EDGE, 1023, 1024, 2, 1);               // shared root on the last edge
    send(CMD_EDGE, 3, 4, 5, 1);                     // after the answer, dropped
    send(CMD_START, 2047, 2047, 20'hFFFFF, 1);      // start ignores its other fields
    send(CMD_EDGE, 5, 6, 20'hFFFFF, 0);             // early answer on the top day
    send(CMD_START, 0, 0, 0, 0);
    send(CMD_EDGE, 7, 8, 1, 0);
    send(CMD_EDGE, 8, 9, 3, 1);                     // early answer beats last
    send(CMD_START, 0, 0, 0, 0);
    send(CMD_EDGE, 0, 0, 0, 1);                     // invalid last edge still answers
    send(CMD_START, 0, 0, 0, 0);
    send(CMD_EDGE, 1024, 1024, 1, 1);               // self loop
    send(CMD_START, 0, 0, 0, 0);
    send(CMD_EDGE, 1024, 1, 20'h80000, 0);
    send(CMD_EDGE, 1, 2, 20'h80000, 1);             // dropped after the answer

    // random phases, one node count each
    for (p = 0; p < 15 || handled < 1350; p++) begin
      if (p < 15) v = schedule[p];
      else if ($urandom_range(9) == 0) v = $urandom_range(1) ? 1 : 2047;
      else v = $urandom_range(2, 48);
      set_node_count(v);
      calm = (p == 8);
      if (p == 5) begin
        // answers pile up behind a held receiver until the input stalls
        hold_req = 1'b1;
        calm     = 1'b1;
        repeat (12) begin
          send(CMD_START, 0, 0, 0, 0);
          send(CMD_EDGE, 1, 2, 9, 1);
        end
      end else begin
        phase_start = sent;
        while (sent - phase_start < 90 && (p < 15 || handled < 1350)) run_graph();
      end
      calm = 1'b0;
    end

    // drain and verdict
    edges.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ union_find_first_gap_day.f @@
design/uffgd_pkg.sv
design/uffgd_if.sv
design/uffgd_ram.sv
design/uffgd_out_reg.sv
design/uffgd_ctrl.sv
design/union_find_first_gap_day.sv
tb/uffgd_checker.sv
tb/tb.sv
